// File: hdl/rrts_pkg.sv
package rrts_pkg;

  localparam int ACTION_W = 2;
  localparam int TID_W    = 4;
  localparam int SLICE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int QCNT_W   = 5;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  // event kinds
  localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POST      = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TERMINATE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_WITHDRAW  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HALTED    = 2'd3;

  // ring read address select
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_HEAD = 2'd1;
  localparam logic [1:0] RD_POS  = 2'd2;
  localparam logic [1:0] RD_NEXT = 2'd3;

  typedef struct packed {
    logic                latch;
    logic [1:0]          rd_src;
    logic                exec;
    logic                wd_init;
    logic                scan_step;
    logic                k_inc;
    logic                shift_wr;
    logic                wd_remove;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                stopped;
    logic                count_zero;
    logic                match;
    logic                scan_last;
  } ctl_sts_t;

endpackage

// File: hdl/rrts_ctrl.sv
module rrts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rrts_pkg::ctl_cmd_t cmd,
  input  rrts_pkg::ctl_sts_t sts
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_RD_HEAD  = 4'd2;
  localparam logic [3:0] S_EXEC     = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_SHIFT_RD = 4'd6;
  localparam logic [3:0] S_SHIFT_WR = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    cmd.rd_src    = rrts_pkg::RD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.stopped) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = rrts_pkg::ST_HALTED;
          state_nxt       = S_DONE;
        end else begin
          unique case (sts.action)
            rrts_pkg::ACT_TICK:      state_nxt = S_RD_HEAD;
            rrts_pkg::ACT_POST:      state_nxt = S_EXEC;
            rrts_pkg::ACT_TERMINATE: state_nxt = S_EXEC;
            rrts_pkg::ACT_WITHDRAW: begin
              if (sts.count_zero) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = rrts_pkg::ST_NOT_FOUND;
                state_nxt       = S_DONE;
              end else begin
                cmd.wd_init = 1'b1;
                state_nxt   = S_SCAN_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD_HEAD: begin
        cmd.rd_src = rrts_pkg::RD_HEAD;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN_RD: begin
        cmd.rd_src = rrts_pkg::RD_POS;
        state_nxt  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (sts.match && sts.scan_last) begin
          cmd.wd_remove = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.match) begin
          state_nxt = S_SHIFT_RD;
        end else if (sts.scan_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = rrts_pkg::ST_NOT_FOUND;
          state_nxt       = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_src = rrts_pkg::RD_NEXT;
        cmd.k_inc  = 1'b1;
        state_nxt  = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (sts.scan_last) begin
          cmd.wd_remove = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        // hold the result until the output slot is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/rrts_datapath.sv
module rrts_datapath #(
  parameter int MAX_THREADS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [rrts_pkg::ACTION_W-1:0]     in_action,
  input  logic [rrts_pkg::TID_W-1:0]        in_thread_id,
  input  logic                              cfg_we,
  input  logic [rrts_pkg::SLICE_W-1:0]      cfg_wdata,
  output logic [rrts_pkg::SLICE_W-1:0]      tslice_len,
  input  rrts_pkg::ctl_cmd_t                cmd,
  output rrts_pkg::ctl_sts_t                sts,
  output logic                              res_switched,
  output logic [rrts_pkg::TID_W-1:0]        res_running_thread,
  output logic                              res_running_live,
  output logic                              res_halted,
  output logic [rrts_pkg::STATUS_W-1:0]     res_status,
  output logic [rrts_pkg::QCNT_W-1:0]       res_queue_count
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_THREADS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_THREADS);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // ready queue storage, contents undefined until written
  logic [rrts_pkg::TID_W-1:0] ring_mem [MAX_THREADS];
  logic [rrts_pkg::TID_W-1:0] rdata_r;
  logic [IW-1:0]              rd_addr;
  logic                       mem_we;
  logic [IW-1:0]              mem_wa;
  logic [rrts_pkg::TID_W-1:0] mem_wd;

  logic [IW-1:0]                  head_r, head_nxt;
  logic [IW-1:0]                  tail_r, tail_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [rrts_pkg::TID_W-1:0]     cur_r, cur_nxt;
  logic                           running_r, running_nxt;
  logic [rrts_pkg::SLICE_W-1:0]   slice_r, slice_nxt;
  logic                           stopped_r, stopped_nxt;
  logic [rrts_pkg::SLICE_W-1:0]   tslice_r;

  logic [rrts_pkg::ACTION_W-1:0]  act_r;
  logic [rrts_pkg::TID_W-1:0]     tid_r;
  logic [rrts_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic                           switched_r, switched_nxt;
  logic [IW-1:0]                  pos_r, pos_nxt;
  logic [CW-1:0]                  k_r, k_nxt;
  logic                           count_zero;

  assign count_zero = (count_r == '0);
  assign tslice_len = tslice_r;

  assign sts.action     = act_r;
  assign sts.stopped    = stopped_r;
  assign sts.count_zero = count_zero;
  assign sts.match      = (rdata_r == tid_r);
  assign sts.scan_last  = ((CW+1)'(k_r) + (CW+1)'(1)) >= (CW+1)'(count_r);

  always_comb begin
    unique case (cmd.rd_src)
      rrts_pkg::RD_HEAD: rd_addr = head_r;
      rrts_pkg::RD_NEXT: rd_addr = ring_next(pos_r);
      default:           rd_addr = pos_r;
    endcase
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    running_nxt  = running_r;
    slice_nxt    = slice_r;
    stopped_nxt  = stopped_r;
    status_nxt   = status_r;
    switched_nxt = switched_r;
    pos_nxt      = pos_r;
    k_nxt        = k_r;
    mem_we       = 1'b0;
    mem_wa       = tail_r;
    mem_wd       = tid_r;

    if (cmd.latch) begin
      status_nxt   = rrts_pkg::ST_OK;
      switched_nxt = 1'b0;
    end
    if (cmd.set_status) begin
      status_nxt = cmd.status_code;
    end

    if (cmd.exec) begin
      unique case (act_r)
        rrts_pkg::ACT_TICK: begin
          priority if (!running_r && count_zero) begin
            stopped_nxt = 1'b1;
          end else if (running_r && slice_r > 8'd1) begin
            slice_nxt = slice_r - 1'b1;
          end else if (running_r && count_zero) begin
            slice_nxt = tslice_r;
          end else begin
            // take the head; head data was read in the previous cycle
            cur_nxt      = rdata_r;
            running_nxt  = 1'b1;
            slice_nxt    = tslice_r;
            switched_nxt = (rdata_r != cur_r);
            head_nxt     = ring_next(head_r);
            if (running_r) begin
              // preempt: old thread to the tail, count unchanged
              mem_we   = 1'b1;
              mem_wd   = cur_r;
              tail_nxt = ring_next(tail_r);
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
        rrts_pkg::ACT_POST: begin
          if (count_r == FULL_CNT) begin
            status_nxt = rrts_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            tail_nxt  = ring_next(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        rrts_pkg::ACT_TERMINATE: running_nxt = 1'b0;
        default: ;
      endcase
    end

    if (cmd.wd_init) begin
      pos_nxt = head_r;
      k_nxt   = '0;
    end
    if (cmd.scan_step) begin
      pos_nxt = ring_next(pos_r);
      k_nxt   = k_r + 1'b1;
    end
    if (cmd.k_inc) begin
      k_nxt = k_r + 1'b1;
    end
    if (cmd.shift_wr) begin
      mem_we  = 1'b1;
      mem_wa  = pos_r;
      mem_wd  = rdata_r;
      pos_nxt = ring_next(pos_r);
    end
    if (cmd.wd_remove) begin
      tail_nxt  = ring_prev(tail_r);
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_src != rrts_pkg::RD_NONE) begin
      rdata_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      cur_r     <= '0;
      running_r <= 1'b1;
      slice_r   <= rrts_pkg::SLICE_RESET;
      stopped_r <= 1'b0;
      tslice_r  <= rrts_pkg::SLICE_RESET;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      running_r <= running_nxt;
      slice_r   <= slice_nxt;
      stopped_r <= stopped_nxt;
      if (cfg_we) begin
        tslice_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_action;
      tid_r <= in_thread_id;
    end
    status_r   <= status_nxt;
    switched_r <= switched_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    if (cmd.load_out) begin
      res_switched       <= switched_r;
      res_running_thread <= cur_r;
      res_running_live   <= running_r;
      res_halted         <= stopped_r;
      res_status         <= status_r;
      res_queue_count    <= rrts_pkg::QCNT_W'(count_r);
    end
  end

endmodule

// File: hdl/round_robin_thread_scheduler_core.sv
// Round-robin time-slice scheduler for thread ids.
// Input channel (in_*): one beat is one event; in_tuser carries the action
// (tick, post, terminate current, withdraw) and in_tdata the thread id.
// Output channel (out_*): exactly one result beat per input beat, in order,
// giving the switch flag, current thread, live flag, halted flag, status
// and the ready-queue fill.
// Configuration (cfg_*): APB-style, register 0 at byte address 0 is the
// timeslice length; write it only while no event is in flight.
// Sequence after accept: a halted or empty-queue event goes from dispatch
// straight to the result; post and terminate pass through the execute
// state, and a tick reads the queue head before it executes; a withdraw
// walks up to queue_count entries of the ready queue (at most MAX_THREADS),
// with a read and a check state per entry checked and a read and a write
// state per entry closed up. The sequencer handles one event at a time;
// the next beat is taken only after the result is registered.
// A result beat that the receiver stalls holds in the output register while
// the next event is taken and worked; that event then waits to deliver.
// Reset: empty queue, thread 0 current and live, slice and length 10.
module round_robin_thread_scheduler_core #(
  parameter int MAX_THREADS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [3:0] thread_id, [7:4] zero
  input  logic [1:0]  in_tuser,    // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] switched, [4:1] running_thread, [5] running_live, [6] halted,
  // [8:7] status, [13:9] queue_count, [15:14] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  rrts_pkg::ctl_cmd_t cmd;
  rrts_pkg::ctl_sts_t sts;

  logic                              cfg_we;
  logic [rrts_pkg::SLICE_W-1:0]      tslice_len;
  logic                              res_switched;
  logic [rrts_pkg::TID_W-1:0]        res_running_thread;
  logic                              res_running_live;
  logic                              res_halted;
  logic [rrts_pkg::STATUS_W-1:0]     res_status;
  logic [rrts_pkg::QCNT_W-1:0]       res_queue_count;

  // register 0 lives at word 0; other words read zero and drop writes
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & ~cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(tslice_len);

  assign out_tdata = {2'b00, res_queue_count, res_status, res_halted,
                      res_running_live, res_running_thread, res_switched};

  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rrts_datapath #(
    .MAX_THREADS (MAX_THREADS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_action          (in_tuser),
    .in_thread_id       (in_tdata[3:0]),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_pwdata[7:0]),
    .tslice_len         (tslice_len),
    .cmd                (cmd),
    .sts                (sts),
    .res_switched       (res_switched),
    .res_running_thread (res_running_thread),
    .res_running_live   (res_running_live),
    .res_halted         (res_halted),
    .res_status         (res_status),
    .res_queue_count    (res_queue_count)
  );

endmodule
